FILE: src/mic_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mic_pkg
// Shared constants for the magnetometer iron calibration block.
// ----------------------------------------------------------------------------
package mic_pkg;

  // pass phase codes
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_HARD = 2'd1;
  localparam logic [1:0] PH_SOFT = 2'd2;

  localparam int NUM_AXES = 3;
  localparam logic [15:0] NUM_SAMPLES_RESET = 16'd256;

endpackage

FILE: src/mic_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mic_in_if / mic_out_if
// Valid/ready channels for sample requests and corrected results.
// ----------------------------------------------------------------------------
interface mic_in_if #(parameter int SampleBits = 16);
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic signed [SampleBits-1:0] sample_x;
  logic signed [SampleBits-1:0] sample_y;
  logic signed [SampleBits-1:0] sample_z;
  modport source (output valid, cmd, sample_x, sample_y, sample_z, input ready);
  modport sink (input valid, cmd, sample_x, sample_y, sample_z, output ready);
endinterface

interface mic_out_if #(parameter int SampleBits = 16);
  logic                         valid;
  logic                         ready;
  logic signed [SampleBits-1:0] corrected_x;
  logic signed [SampleBits-1:0] corrected_y;
  logic signed [SampleBits-1:0] corrected_z;
  logic [1:0]                   phase;
  logic                         calibration_done;
  modport source (output valid, corrected_x, corrected_y, corrected_z, phase,
                  calibration_done, input ready);
  modport sink (input valid, corrected_x, corrected_y, corrected_z, phase,
                calibration_done, output ready);
endinterface

FILE: src/mic_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mic_lane
// One axis: correction multiply, min/max tracking, offset and gain store.
// ----------------------------------------------------------------------------
module mic_lane #(
  parameter int SampleBits   = 16,
  parameter int GainFracBits = 12
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start_cal,    // reset offset/gain
  input  logic                            mul_en,       // stage 1 capture
  input  logic signed [SampleBits-1:0]    sample,
  input  logic                            track_en,     // stage 2 track
  input  logic                            track_first,
  input  logic                            set_offset,
  input  logic                            set_gain,
  input  logic [GainFracBits+3:0]         gain_in,
  output logic signed [SampleBits-1:0]    corrected,
  output logic [SampleBits:0]             diam
);
  localparam int GW = GainFracBits + 4;
  localparam int PW = SampleBits + 1 + GW + 1;
  localparam logic signed [SampleBits-1:0] SMAX = {1'b0, {(SampleBits-1){1'b1}}};
  localparam logic signed [SampleBits-1:0] SMIN = {1'b1, {(SampleBits-1){1'b0}}};
  localparam logic [GW-1:0] GUNITY = GW'(1) << GainFracBits;

  logic signed [SampleBits-1:0] off_r, min_r, max_r;
  logic signed [SampleBits-1:0] min_nxt, max_nxt;
  logic [GW-1:0]                gain_r;
  logic signed [SampleBits-1:0] off_use;
  logic [GW-1:0]                gain_use;
  logic signed [PW-1:0]         prod_r;
  logic signed [SampleBits:0]   diff;
  logic signed [PW-1:0]         rnd, shf;
  logic signed [SampleBits-1:0] corr;
  logic signed [SampleBits:0]   midsum;

  // a starting calibration corrects with identity
  assign off_use  = start_cal ? '0 : off_r;
  assign gain_use = start_cal ? GUNITY : gain_r;

  // difference and product, registered
  assign diff = $signed({sample[SampleBits-1], sample})
                - $signed({off_use[SampleBits-1], off_use});
  always_ff @(posedge clk) begin
    if (mul_en) prod_r <= PW'(diff) * $signed({1'b0, gain_use});
  end

  // round, floor shift, saturate
  always_comb begin
    rnd = prod_r + PW'(1 << (GainFracBits - 1));
    shf = rnd >>> GainFracBits;
    if (shf > PW'(SMAX)) corr = SMAX;
    else if (shf < PW'(SMIN)) corr = SMIN;
    else corr = shf[SampleBits-1:0];
  end
  assign corrected = corr;

  // extremes including the sample being tracked
  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    if (track_en) begin
      if (track_first || corr < min_r) min_nxt = corr;
      if (track_first || corr > max_r) max_nxt = corr;
    end
  end

  // offset, gain and extremes
  assign midsum = $signed({min_nxt[SampleBits-1], min_nxt})
                  + $signed({max_nxt[SampleBits-1], max_nxt});
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r  <= '0;
      gain_r <= GUNITY;
      min_r  <= '0;
      max_r  <= '0;
    end else begin
      if (start_cal) begin
        off_r  <= '0;
        gain_r <= GUNITY;
      end else if (set_offset) begin
        off_r <= midsum[SampleBits:1];
      end else if (set_gain) begin
        gain_r <= gain_in;
      end
      min_r <= min_nxt;
      max_r <= max_nxt;
    end
  end

  assign diam = (max_nxt > min_nxt) ?
      ({max_nxt[SampleBits-1], max_nxt} - {min_nxt[SampleBits-1], min_nxt}) : '0;
endmodule

FILE: src/mic_gain_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mic_gain_div
// Merging stage: sums lane diameters and runs a shared restoring divider
// for the three gains, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mic_gain_div #(
  parameter int SampleBits   = 16,
  parameter int GainFracBits = 12
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [SampleBits:0]     diam_x,
  input  logic [SampleBits:0]     diam_y,
  input  logic [SampleBits:0]     diam_z,
  output logic                    busy,
  output logic                    gain_we,
  output logic [1:0]              gain_axis,
  output logic [GainFracBits+3:0] gain_out
);
  localparam int GW = GainFracBits + 4;
  localparam int NW = SampleBits + 3 + GainFracBits;   // numerator width
  localparam int DW = SampleBits + 3;                  // 3*D width
  localparam int QW = NW;
  localparam int CW = $clog2(QW + 1);
  localparam logic [GW-1:0] GMAX = '1;

  logic [NW-1:0]   num_r, rem_r;
  logic [DW-1:0]   den_r;
  logic [QW-1:0]   quo_r;
  logic [CW-1:0]   bit_r;
  logic [1:0]      axis_r;
  logic            run_r, fin_r;
  logic [DW-1:0]   den_sel;
  logic [SampleBits:0] d_sel;
  logic [NW:0]     trial;
  logic [NW-1:0]   num_rnd;
  logic [QW:0]     qfin;

  always_comb begin
    unique case (axis_r)
      2'd0: d_sel = diam_x;
      2'd1: d_sel = diam_y;
      default: d_sel = diam_z;
    endcase
  end
  assign den_sel = DW'(d_sel) + DW'({d_sel, 1'b0});

  // one quotient bit per cycle of (num + den/2) / den
  assign num_rnd = num_r + NW'(den_r >> 1);
  assign trial   = {rem_r, num_rnd[bit_r[CW-1:0] - CW'(1)]} - (NW+1)'(den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      axis_r <= 2'd0;
      bit_r  <= '0;
    end else begin
      fin_r <= 1'b0;
      if (start) begin
        num_r  <= NW'(({2'b0, diam_x} + {2'b0, diam_y} + {2'b0, diam_z})) << GainFracBits;
        axis_r <= 2'd0;
        run_r  <= 1'b1;
        bit_r  <= '0;
      end else if (run_r) begin
        if (bit_r == '0) begin
          // load the next axis once the previous gain has been written
          if (!fin_r) begin
            den_r <= den_sel;
            rem_r <= '0;
            quo_r <= '0;
            bit_r <= CW'(QW);
          end
        end else begin
          if (!trial[NW]) begin
            rem_r <= trial[NW-1:0];
            quo_r <= {quo_r[QW-2:0], 1'b1};
          end else begin
            rem_r <= {rem_r[NW-2:0], num_rnd[bit_r - CW'(1)]};
            quo_r <= {quo_r[QW-2:0], 1'b0};
          end
          bit_r <= bit_r - CW'(1);
          if (bit_r == CW'(1)) fin_r <= 1'b1;
        end
      end
      if (fin_r) begin
        if (axis_r == 2'd2) run_r <= 1'b0;
        axis_r <= axis_r + 2'd1;
      end
    end
  end

  assign qfin      = {1'b0, quo_r};
  assign busy      = run_r;
  assign gain_we   = fin_r;
  assign gain_axis = axis_r;
  assign gain_out  = (den_r == '0 || qfin > (QW+1)'(GMAX)) ? GMAX : quo_r[GW-1:0];
endmodule

FILE: src/magnetometer_iron_calibration.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magnetometer_iron_calibration
// Per-axis hard/soft iron correction with min/max calibration passes.
// ----------------------------------------------------------------------------
// A correction request first captures (sample - offset) * gain in the three
// axis lanes, then rounds and saturates, and for a calibration request tracks
// min/max. The result sits in an output register; a new request is taken only
// once that register is empty or its result leaves in the same cycle. The
// request that ends the soft iron pass additionally stalls the input while
// the shared divider computes the three gains, one quotient bit a cycle with
// a load and a write step per axis.
module magnetometer_iron_calibration
  import mic_pkg::*;
#(
  parameter int SAMPLE_BITS    = 16,
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  mic_in_if.sink      in_ch,
  mic_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  logic [15:0] num_r, cnt_r, cnt_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic        s2_r, cmd_r, first_r;
  logic        ovalid_r, done_r, ph_cal;
  logic        last;
  logic signed [SAMPLE_BITS-1:0] c [NUM_AXES];
  logic signed [SAMPLE_BITS-1:0] s [NUM_AXES];
  logic [SAMPLE_BITS:0] dm [NUM_AXES];
  logic [GAIN_FRAC_BITS+3:0] gdiv;
  logic busy, gwe;
  logic [1:0] gax;
  logic take, start_cal;

  assign s[0] = in_ch.sample_x;
  assign s[1] = in_ch.sample_y;
  assign s[2] = in_ch.sample_z;

  // accept when stage 2 empty, output free after it, divider idle
  assign in_ch.ready = !s2_r && !busy && !(ovalid_r && !out_ch.ready);
  assign take      = in_ch.valid && in_ch.ready;
  assign start_cal = take && in_ch.cmd && ph_r == PH_IDLE;

  // pass bookkeeping for stage 2
  assign ph_cal  = s2_r && cmd_r;
  assign cnt_nxt = cnt_r + 16'd1;
  assign last    = (cnt_nxt == 16'd0) || (cnt_nxt >= num_r);

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    mic_lane #(.SampleBits(SAMPLE_BITS), .GainFracBits(GAIN_FRAC_BITS)) u_lane (
      .clk, .rst_n,
      .start_cal  (start_cal),
      .mul_en     (take),
      .sample     (s[a]),
      .track_en   (ph_cal),
      .track_first(first_r),
      .set_offset (ph_cal && last && ph_r == PH_HARD),
      .set_gain   (gwe && gax == 2'(a)),
      .gain_in    (gdiv),
      .corrected  (c[a]),
      .diam       (dm[a])
    );
  end

  mic_gain_div #(.SampleBits(SAMPLE_BITS), .GainFracBits(GAIN_FRAC_BITS)) u_div (
    .clk, .rst_n,
    .start    (ph_cal && last && ph_r == PH_SOFT),
    .diam_x   (dm[0]), .diam_y(dm[1]), .diam_z(dm[2]),
    .busy     (busy),
    .gain_we  (gwe),
    .gain_axis(gax),
    .gain_out (gdiv)
  );

  always_comb begin
    ph_nxt = ph_r;
    if (start_cal) ph_nxt = PH_HARD;
    else if (ph_cal && last) ph_nxt = (ph_r == PH_HARD) ? PH_SOFT : PH_IDLE;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r    <= NUM_SAMPLES_RESET;
      cnt_r    <= '0;
      ph_r     <= PH_IDLE;
      s2_r     <= 1'b0;
      cmd_r    <= 1'b0;
      first_r  <= 1'b0;
      ovalid_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      if (cfg_we) num_r <= cfg_wdata;
      s2_r <= take;
      if (take) begin
        cmd_r   <= in_ch.cmd;
        first_r <= start_cal || cnt_r == 16'd0;
      end
      ph_r <= ph_nxt;
      if (start_cal) cnt_r <= '0;
      else if (ph_cal) cnt_r <= last ? 16'd0 : cnt_nxt;
      if (s2_r) begin
        ovalid_r <= 1'b1;
        done_r   <= ph_cal && last && ph_r == PH_SOFT;
      end else if (out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (s2_r) begin
      out_ch.corrected_x <= c[0];
      out_ch.corrected_y <= c[1];
      out_ch.corrected_z <= c[2];
      out_ch.phase       <= ph_nxt;
    end
  end
  assign out_ch.valid            = ovalid_r;
  assign out_ch.calibration_done = done_r;
endmodule

FILE: src/mic_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mic_checker
// Port-level checks for the magnetometer iron calibration block.
// ----------------------------------------------------------------------------
module mic_checker
  import mic_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_phase,
  input logic       out_done
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_phase != 2'd3) else $error("bad phase");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done |-> out_phase == PH_IDLE) else $error("done not idle");
  a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("request taken back to back");
endmodule

bind magnetometer_iron_calibration mic_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_phase(out_ch.phase), .out_done(out_ch.calibration_done)
);

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for magnetometer_iron_calibration. Sample requests are
// driven over the input channel with random gaps; every corrected result is
// checked against a cycle-free model of the correction and of the two min/max
// calibration passes, run at several pass lengths including the extremes.
// ----------------------------------------------------------------------------
module testbench;
  import mic_pkg::*;

  localparam int  GAIN_FRAC = 12;
  localparam int  GAIN_SAT  = (1 << (GAIN_FRAC + 4)) - 1;
  localparam int  DRAIN_CYCLES = 250;
  localparam logic CMD_CORRECT = 1'b0;
  localparam logic CMD_CALIB   = 1'b1;

  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] cz;
    logic [1:0]         phase;
    logic               done;
  } corrected_t;

  // model of the calibration state and queue of pending corrected results
  class iron_scoreboard;
    corrected_t  pending[$];
    int          offset[3];
    int          gain[3];
    int          amin[3];
    int          amax[3];
    logic [1:0]  pass_phase;
    int          count;
    int          num_samples;
    int          errors;

    function new();
      for (int a = 0; a < 3; a++) begin
        offset[a] = 0;
        gain[a]   = 1 << GAIN_FRAC;
        amin[a]   = 0;
        amax[a]   = 0;
      end
      pass_phase  = PH_IDLE;
      count       = 0;
      num_samples = int'(NUM_SAMPLES_RESET);
      errors      = 0;
    endfunction

    function int correct_axis(int a, int s);
      longint p, r;
      p = (longint'(s) - longint'(offset[a])) * longint'(gain[a]);
      r = (p + (longint'(1) << (GAIN_FRAC - 1))) >>> GAIN_FRAC;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return int'(r);
    endfunction

    function void finish_gain();
      longint d[3];
      longint num, den, q;
      for (int a = 0; a < 3; a++)
        d[a] = (amax[a] > amin[a]) ? longint'(amax[a] - amin[a]) : longint'(0);
      num = (d[0] + d[1] + d[2]) << GAIN_FRAC;
      for (int a = 0; a < 3; a++) begin
        den = 3 * d[a];
        if (den == 0) q = GAIN_SAT;
        else begin
          q = (num + den / 2) / den;
          if (q > GAIN_SAT) q = GAIN_SAT;
        end
        gain[a] = int'(q);
      end
    endfunction

    function void note_request(logic cmd, logic signed [15:0] x, logic signed [15:0] y,
                               logic signed [15:0] z);
      int s[3];
      int c[3];
      logic done;
      corrected_t e;
      s[0] = int'(x); s[1] = int'(y); s[2] = int'(z);
      done = 1'b0;
      // start of calibration resets the correction to identity
      if (cmd == CMD_CALIB && pass_phase == PH_IDLE) begin
        for (int a = 0; a < 3; a++) begin
          offset[a] = 0;
          gain[a]   = 1 << GAIN_FRAC;
        end
        pass_phase = PH_HARD;
        count = 0;
      end
      for (int a = 0; a < 3; a++) c[a] = correct_axis(a, s[a]);
      if (cmd == CMD_CALIB) begin
        for (int a = 0; a < 3; a++) begin
          if (count == 0 || c[a] < amin[a]) amin[a] = c[a];
          if (count == 0 || c[a] > amax[a]) amax[a] = c[a];
        end
        count = (count + 1) & 16'hFFFF;
        if (count == 0 || count >= num_samples) begin
          if (pass_phase == PH_HARD) begin
            for (int a = 0; a < 3; a++) offset[a] = (amin[a] + amax[a]) >>> 1;
            pass_phase = PH_SOFT;
          end else begin
            finish_gain();
            pass_phase = PH_IDLE;
            done = 1'b1;
          end
          count = 0;
        end
      end
      e.cx = c[0][15:0];
      e.cy = c[1][15:0];
      e.cz = c[2][15:0];
      e.phase = pass_phase;
      e.done = done;
      pending.push_back(e);
    endfunction

    function void check_result(corrected_t got);
      corrected_t e;
      if (pending.size() == 0) begin
        $error("result with no request pending");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.cx !== e.cx) begin
        $error("corrected_x expected %0d actual %0d", e.cx, got.cx); errors++;
      end
      if (got.cy !== e.cy) begin
        $error("corrected_y expected %0d actual %0d", e.cy, got.cy); errors++;
      end
      if (got.cz !== e.cz) begin
        $error("corrected_z expected %0d actual %0d", e.cz, got.cz); errors++;
      end
      if (got.phase !== e.phase) begin
        $error("phase expected %0d actual %0d", e.phase, got.phase); errors++;
      end
      if (got.done !== e.done) begin
        $error("calibration_done expected %0d actual %0d", e.done, got.done); errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  iron_scoreboard sb = new();

  mic_in_if  in_ch ();
  mic_out_if out_ch ();

  magnetometer_iron_calibration dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = 1'b0;
    in_ch.sample_x = '0;
    in_ch.sample_y = '0;
    in_ch.sample_z = '0;
    out_ch.ready = 1'b0;
  end

  // result receiver with random stalls and one long hold-off
  initial begin
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    corrected_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.cx = out_ch.corrected_x;
      got.cy = out_ch.corrected_y;
      got.cz = out_ch.corrected_z;
      got.phase = out_ch.phase;
      got.done = out_ch.calibration_done;
      sb.check_result(got);
    end
  end

  // one request; called at a rising edge, returns at the accepting edge
  task automatic send_request(logic cmd, logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z);
    int gap;
    gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(1, 8);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.sample_x <= x;
    in_ch.sample_y <= y;
    in_ch.sample_z <= z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(cmd, x, y, z);
  endtask

  // register write once the block has drained
  task automatic write_num_samples(logic [15:0] value);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.num_samples = int'(value);
  endtask

  function automatic logic signed [15:0] near(int center, int radius);
    int v;
    v = center + int'($urandom_range(0, 2 * radius)) - radius;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] any_value();
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  // one calibration run: two passes of n samples, some corrections mixed in
  task automatic run_calibration(int n, int noise_pct);
    int cx, cy, cz, rx, ry, rz, fed;
    cx = int'($urandom_range(0, 20000)) - 10000;
    cy = int'($urandom_range(0, 20000)) - 10000;
    cz = int'($urandom_range(0, 20000)) - 10000;
    rx = $urandom_range(0, 12000);
    ry = $urandom_range(0, 12000);
    rz = $urandom_range(0, 12000);
    fed = 0;
    while (fed < 2 * n) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_request(CMD_CORRECT, any_value(), any_value(), any_value());
      end else begin
        send_request(CMD_CALIB, near(cx, rx), near(cy, ry), near(cz, rz));
        fed++;
      end
    end
  endtask

  initial begin
    int sent;
    int n;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: identity correction at the field extremes
    send_request(CMD_CORRECT, 16'sh7FFF, -16'sh8000, 16'sh0000);
    send_request(CMD_CORRECT, -16'sh0001, 16'sh0001, 16'sh7FFF);
    // one-sample passes with equal samples: zero diameter saturates the gain
    write_num_samples(16'd1);
    send_request(CMD_CALIB, 16'sh0100, -16'sh0100, 16'sh0000);
    send_request(CMD_CALIB, 16'sh0100, -16'sh0100, 16'sh0000);
    send_request(CMD_CORRECT, 16'sh7FFF, -16'sh8000, 16'sh0101);
    send_request(CMD_CORRECT, 16'sh0100, -16'sh00FF, 16'sh0002);
    // two-sample passes with a correction in between
    write_num_samples(16'd2);
    send_request(CMD_CALIB, 16'sh1000, -16'sh2000, 16'sh0300);
    send_request(CMD_CORRECT, 16'sh7FFF, 16'sh7FFF, -16'sh8000);
    send_request(CMD_CALIB, -16'sh1000, 16'sh2000, -16'sh0300);
    send_request(CMD_CALIB, 16'sh0800, -16'sh0400, 16'sh0100);
    send_request(CMD_CALIB, -16'sh0900, 16'sh0500, -16'sh0200);
    send_request(CMD_CORRECT, 16'sh1234, -16'sh4321, 16'sh0FFF);
    send_request(CMD_CORRECT, -16'sh8000, 16'sh7FFF, -16'sh8000);
    // full-range two-sample calibration
    send_request(CMD_CALIB, 16'sh7FFF, -16'sh8000, 16'sh7FFF);
    send_request(CMD_CALIB, -16'sh8000, 16'sh7FFF, -16'sh8000);
    send_request(CMD_CALIB, 16'sh7FFF, 16'sh7FFF, 16'sh0000);
    send_request(CMD_CALIB, -16'sh8000, -16'sh8000, 16'sh0000);
    send_request(CMD_CORRECT, 16'sh0000, 16'sh4000, -16'sh4000);

    // long receiver hold-off while requests keep coming
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_request(CMD_CORRECT, any_value(), any_value(), any_value());

    // random calibration runs at assorted pass lengths
    sent = 0;
    while (sent < 560) begin
      case ($urandom_range(0, 3))
        0: n = 1;
        1: n = $urandom_range(2, 4);
        2: n = $urandom_range(5, 12);
        default: n = $urandom_range(13, 40);
      endcase
      write_num_samples(n[15:0]);
      run_calibration(n, 20);
      for (int i = 0; i < 6; i++) send_request(CMD_CORRECT, any_value(), any_value(), any_value());
      sent += 2 * n + 6;
    end

    // longest pass length, left unfinished, then zero ends it early
    write_num_samples(16'hFFFF);
    for (int i = 0; i < 30; i++) send_request(CMD_CALIB, any_value(), any_value(), any_value());
    write_num_samples(16'd0);
    send_request(CMD_CALIB, any_value(), any_value(), any_value());
    send_request(CMD_CALIB, any_value(), any_value(), any_value());
    send_request(CMD_CALIB, any_value(), any_value(), any_value());

    // closing stretch without idling
    quiet = 1'b1;
    write_num_samples(16'd8);
    run_calibration(8, 10);
    for (int i = 0; i < 60; i++) send_request(CMD_CORRECT, any_value(), any_value(), any_value());
    in_ch.valid <= 1'b0;

    // drain
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: sim.f
src/mic_pkg.sv
src/mic_if.sv
src/mic_lane.sv
src/mic_gain_div.sv
src/magnetometer_iron_calibration.sv
src/mic_checker.sv
verif/testbench.sv
